>>> hdl/tfnu_pkg.sv
// ----------------------------------------------------------------------------
// tfnu_pkg
// Shared constants and types for the triangle face normal block.
// ----------------------------------------------------------------------------
package tfnu_pkg;

  localparam int COORD_BITS_DEF       = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int INDEX_BITS_DEF       = 32;
  localparam int VERTS_PER_TRI        = 3;

  // register byte addresses
  localparam logic [1:0] REG_CLOCKWISE = 2'd0;

  // vertex slot within a triangle
  typedef enum logic [1:0] {
    SLOT_V0 = 2'd0,
    SLOT_V1 = 2'd1,
    SLOT_V2 = 2'd2
  } slot_t;

endpackage

>>> hdl/tfnu_div.sv
// ----------------------------------------------------------------------------
// tfnu_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tfnu_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 16,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_vld,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] tag_out
);
  // quotient assumed to fit in QW bits: num < den << QW
  logic [DW:0]   rem_r [QW+1];
  logic [NW-1:0] num_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [TW-1:0] tag_r [QW+1];
  logic          vld_r [QW+1];

  always_comb begin
    rem_r[0] = (DW+1)'(num[NW-1:QW]);
    num_r[0] = num;
    den_r[0] = den;
    q_r[0]   = '0;
    tag_r[0] = tag_in;
    vld_r[0] = in_vld;
  end

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    always_comb begin
      sh = {rem_r[s], num_r[s][NW-1-(NW-QW)-s]};
      df = sh - {2'b00, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (adv) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (adv) begin
        rem_r[s+1] <= df[DW+1] ? sh[DW:0] : df[DW:0];
        q_r[s+1]   <= {q_r[s][QW-2:0], ~df[DW+1]};
        num_r[s+1] <= num_r[s];
        den_r[s+1] <= den_r[s];
        tag_r[s+1] <= tag_r[s];
      end
    end
  end

  // high NW-QW bits of num preload the remainder
  assign out_vld = vld_r[QW];
  assign quo     = q_r[QW];
  assign tag_out = tag_r[QW];
endmodule

>>> hdl/triangle_face_normal_unindex_core.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_unindex_core
// Unit face normal of one triangle, emitted as three unindexed vertices.
// ----------------------------------------------------------------------------
// One triangle is taken per transfer on the in_ channel and yields three
// vertex transfers on the out_ channel, v0, v1, v2, one per cycle while
// out_ready is high, so the sustained rate is one triangle per three output
// transfers, set by the output port. Work is a deep pipeline (edges, cross
// product, magnitude, normalize shift, squares, square root bit by bit,
// divisions bit by bit); it is stalled as a whole when its last stage is
// full and not drained. Normals are Q1.14, negated when clockwise_faces is
// set; a zero cross product gives a zero normal with degenerate set.
// ----------------------------------------------------------------------------
module triangle_face_normal_unindex_core #(
  parameter int COORD_BITS       = tfnu_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = tfnu_pkg::NORMAL_FRAC_BITS_DEF,
  parameter int INDEX_BITS       = tfnu_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [1:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  in_v0_x,
  input  logic signed [COORD_BITS-1:0]  in_v0_y,
  input  logic signed [COORD_BITS-1:0]  in_v0_z,
  input  logic signed [COORD_BITS-1:0]  in_v1_x,
  input  logic signed [COORD_BITS-1:0]  in_v1_y,
  input  logic signed [COORD_BITS-1:0]  in_v1_z,
  input  logic signed [COORD_BITS-1:0]  in_v2_x,
  input  logic signed [COORD_BITS-1:0]  in_v2_y,
  input  logic signed [COORD_BITS-1:0]  in_v2_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [INDEX_BITS-1:0]         out_vertex_index,
  output logic signed [COORD_BITS-1:0]  out_pos_x,
  output logic signed [COORD_BITS-1:0]  out_pos_y,
  output logic signed [COORD_BITS-1:0]  out_pos_z,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_y,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_z,
  output logic                          out_degenerate,
  output logic                          out_last_of_triangle
);
  localparam int CB  = COORD_BITS;
  localparam int F   = NORMAL_FRAC_BITS;
  localparam int NW  = F + 2;
  localparam int EW  = (CB + 1 > 32) ? 32 : CB + 1;    // edge width after scaling
  localparam int PW  = 2 * EW;                         // product width
  localparam int XW  = PW + 1;                         // cross product width
  localparam int AW  = 30;                             // normalized magnitude
  localparam int SW  = 2 * AW + 2;                     // sum of squares
  localparam int RW  = AW + 1;                         // square root width
  localparam int LW  = $clog2(XW + 1);
  localparam int VW  = 9 * CB;
  localparam int DNW = AW + F + 1;                     // dividend width
  localparam int QW  = F + 2;

  // ---------------- configuration ----------------
  logic cw_r;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == tfnu_pkg::REG_CLOCKWISE) begin
      cw_r <= cfg_pwdata[0];
    end
  end
  assign cfg_prdata = {31'd0, cw_r};

  // ---------------- global stall ----------------
  // pipeline advances whenever the output holding stage can take an item
  logic adv;
  logic oh_vld_r;
  logic [1:0] slot_r;
  logic last_pop;
  assign last_pop = oh_vld_r && out_ready && slot_r == tfnu_pkg::SLOT_V2;
  logic fin_vld;
  assign adv      = !oh_vld_r || last_pop;
  assign in_ready = adv;

  // ---------------- stage 1: edges ----------------
  logic          s1_vld_r;
  logic [VW-1:0] s1_v_r;
  logic signed [CB:0] e1_r [3];
  logic signed [CB:0] e2_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (adv) s1_vld_r <= in_valid;
    if (adv) begin
      s1_v_r <= {in_v0_x, in_v0_y, in_v0_z, in_v1_x, in_v1_y, in_v1_z,
                 in_v2_x, in_v2_y, in_v2_z};
      e1_r[0] <= {in_v1_x[CB-1], in_v1_x} - {in_v0_x[CB-1], in_v0_x};
      e1_r[1] <= {in_v1_y[CB-1], in_v1_y} - {in_v0_y[CB-1], in_v0_y};
      e1_r[2] <= {in_v1_z[CB-1], in_v1_z} - {in_v0_z[CB-1], in_v0_z};
      e2_r[0] <= {in_v2_x[CB-1], in_v2_x} - {in_v0_x[CB-1], in_v0_x};
      e2_r[1] <= {in_v2_y[CB-1], in_v2_y} - {in_v0_y[CB-1], in_v0_y};
      e2_r[2] <= {in_v2_z[CB-1], in_v2_z} - {in_v0_z[CB-1], in_v0_z};
    end
  end

  // ---------------- stage 2: wide-coordinate scaling ----------------
  // halves all six until each magnitude is below 2^31 (only at CB > 31)
  logic signed [EW-1:0] e1s_r [3];
  logic signed [EW-1:0] e2s_r [3];
  logic          s2_vld_r;
  logic [VW-1:0] s2_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (adv) s2_vld_r <= s1_vld_r;
    if (adv) s2_v_r <= s1_v_r;
  end
  for (genvar i = 0; i < 3; i++) begin : g_sc
    if (CB + 1 <= 32) begin : g_nar
      always_ff @(posedge clk) if (adv) begin
        e1s_r[i] <= EW'(e1_r[i]);
        e2s_r[i] <= EW'(e2_r[i]);
      end
    end else begin : g_wide
      // shift count k: smallest k with all |e >> k| < 2^31 (truncating to zero)
      logic [CB:0] mx;
      logic [5:0]  k;
      logic [CB:0] ma, mb;
      always_comb begin
        mx = '0;
        for (int j = 0; j < 3; j++) begin
          ma = e1_r[j][CB] ? -e1_r[j] : e1_r[j];
          mb = e2_r[j][CB] ? -e2_r[j] : e2_r[j];
          mx = mx | ma | mb;
        end
        k = '0;
        for (int b = 31; b <= CB; b++) if (mx[b]) k = 6'(b - 30);
        ma = e1_r[i][CB] ? -e1_r[i] : e1_r[i];
        mb = e2_r[i][CB] ? -e2_r[i] : e2_r[i];
        ma = ma >> k;
        mb = mb >> k;
      end
      always_ff @(posedge clk) if (adv) begin
        e1s_r[i] <= EW'(e1_r[i][CB] ? -ma : ma);
        e2s_r[i] <= EW'(e2_r[i][CB] ? -mb : mb);
      end
    end
  end

  // ---------------- stage 3: products ----------------
  logic signed [PW-1:0] pa_r [3];
  logic signed [PW-1:0] pb_r [3];
  logic          s3_vld_r;
  logic [VW-1:0] s3_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (adv) s3_vld_r <= s2_vld_r;
    if (adv) begin
      s3_v_r <= s2_v_r;
      pa_r[0] <= e1s_r[1] * e2s_r[2];
      pb_r[0] <= e1s_r[2] * e2s_r[1];
      pa_r[1] <= e1s_r[2] * e2s_r[0];
      pb_r[1] <= e1s_r[0] * e2s_r[2];
      pa_r[2] <= e1s_r[0] * e2s_r[1];
      pb_r[2] <= e1s_r[1] * e2s_r[0];
    end
  end

  // ---------------- stage 4: cross product, magnitudes ----------------
  logic [XW-1:0] a4_r [3];
  logic [2:0]    neg4_r;
  logic          s4_vld_r;
  logic [VW-1:0] s4_v_r;
  logic signed [XW-1:0] cx [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      cx[i] = {pa_r[i][PW-1], pa_r[i]} - {pb_r[i][PW-1], pb_r[i]};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (adv) s4_vld_r <= s3_vld_r;
    if (adv) begin
      s4_v_r <= s3_v_r;
      for (int i = 0; i < 3; i++) begin
        a4_r[i]   <= cx[i][XW-1] ? XW'(-cx[i]) : XW'(cx[i]);
        neg4_r[i] <= cx[i][XW-1];
      end
    end
  end

  // ---------------- stage 5: leading one of max ----------------
  logic [XW-1:0] a5_r [3];
  logic [2:0]    neg5_r;
  logic [LW-1:0] lead5_r;
  logic          zero5_r;
  logic          s5_vld_r;
  logic [VW-1:0] s5_v_r;
  logic [XW-1:0] orv;
  logic [LW-1:0] lead;
  always_comb begin
    orv  = a4_r[0] | a4_r[1] | a4_r[2];
    lead = '0;
    for (int b = 0; b < XW; b++) if (orv[b]) lead = LW'(b);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else if (adv) s5_vld_r <= s4_vld_r;
    if (adv) begin
      s5_v_r  <= s4_v_r;
      a5_r    <= a4_r;
      neg5_r  <= neg4_r;
      lead5_r <= lead;
      zero5_r <= (orv == '0);
    end
  end

  // ---------------- stage 6: normalize max into [2^29, 2^30) ----------------
  // leading one of the OR equals that of the max
  logic [AW-1:0] a6_r [3];
  logic [2:0]    neg6_r;
  logic          zero6_r;
  logic          s6_vld_r;
  logic [VW-1:0] s6_v_r;
  logic [XW+AW-1:0] shx [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead5_r >= LW'(29))
        shx[i] = (XW+AW)'(a5_r[i]) >> (lead5_r - LW'(29));
      else
        shx[i] = (XW+AW)'(a5_r[i]) << (LW'(29) - lead5_r);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else if (adv) s6_vld_r <= s5_vld_r;
    if (adv) begin
      s6_v_r  <= s5_v_r;
      neg6_r  <= neg5_r;
      zero6_r <= zero5_r;
      for (int i = 0; i < 3; i++) a6_r[i] <= shx[i][AW-1:0];
    end
  end

  // ---------------- stage 7: squares ----------------
  logic [2*AW-1:0] sq7_r [3];
  logic [AW-1:0]   a7_r [3];
  logic [2:0]      neg7_r;
  logic            zero7_r;
  logic            s7_vld_r;
  logic [VW-1:0]   s7_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s7_vld_r <= 1'b0;
    else if (adv) s7_vld_r <= s6_vld_r;
    if (adv) begin
      s7_v_r  <= s6_v_r;
      a7_r    <= a6_r;
      neg7_r  <= neg6_r;
      zero7_r <= zero6_r;
      for (int i = 0; i < 3; i++) sq7_r[i] <= a6_r[i] * a6_r[i];
    end
  end

  // ---------------- stage 8: sum ----------------
  logic [SW-1:0] s8_r;
  logic [AW-1:0] a8_r [3];
  logic [2:0]    neg8_r;
  logic          zero8_r;
  logic          s8_vld_r;
  logic [VW-1:0] s8_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s8_vld_r <= 1'b0;
    else if (adv) s8_vld_r <= s7_vld_r;
    if (adv) begin
      s8_v_r  <= s7_v_r;
      a8_r    <= a7_r;
      neg8_r  <= neg7_r;
      zero8_r <= zero7_r;
      s8_r    <= SW'(sq7_r[0]) + SW'(sq7_r[1]) + SW'(sq7_r[2]);
    end
  end

  // ---------------- square root: one result bit per stage ----------------
  localparam int NSQ = SW / 2;
  localparam int TGW = VW + 3 * AW + 4;
  logic [SW-1:0]  sq_rem [NSQ+1];
  logic [NSQ-1:0] sq_res [NSQ+1];
  logic [SW-1:0]  sq_src [NSQ+1];
  logic [TGW-1:0] sq_tag [NSQ+1];
  logic           sq_vld [NSQ+1];
  always_comb begin
    sq_rem[0] = '0;
    sq_res[0] = '0;
    sq_src[0] = s8_r;
    sq_tag[0] = {s8_v_r, a8_r[0], a8_r[1], a8_r[2], neg8_r, zero8_r};
    sq_vld[0] = s8_vld_r;
  end
  for (genvar s = 0; s < NSQ; s++) begin : g_sq
    logic [SW+1:0] rm, tr;
    always_comb begin
      rm = {sq_rem[s][SW-1:0], sq_src[s][SW-1-2*s -: 2]};
      tr = rm - {(SW+2-NSQ-2)'(0), sq_res[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld[s+1] <= 1'b0;
      else if (adv) sq_vld[s+1] <= sq_vld[s];
      if (adv) begin
        sq_rem[s+1] <= tr[SW+1] ? rm[SW-1:0] : tr[SW-1:0];
        sq_res[s+1] <= {sq_res[s][NSQ-2:0], ~tr[SW+1]};
        sq_src[s+1] <= sq_src[s];
        sq_tag[s+1] <= sq_tag[s];
      end
    end
  end

  // ---------------- dividers, one per axis ----------------
  logic [RW-1:0]  r_sq;
  logic [VW-1:0]  v_sq;
  logic [AW-1:0]  a_sq [3];
  logic [2:0]     n_sq;
  logic           z_sq;
  assign r_sq = RW'(sq_res[NSQ]);
  assign {v_sq, a_sq[0], a_sq[1], a_sq[2], n_sq, z_sq} = sq_tag[NSQ];

  localparam int DTW = VW + 4;
  logic [QW-1:0]  qv [3];
  logic [DTW-1:0] dtag [3];
  logic           dvld [3];
  for (genvar i = 0; i < 3; i++) begin : g_dv
    logic [DNW-1:0] num;
    // r >= 2^29 so a*2^F + r/2 < r * 2^(F+2)
    assign num = (DNW'(a_sq[i]) << F) + DNW'(r_sq >> 1);
    tfnu_div #(.NW(DNW + (RW - (DNW - QW) > 0 ? 0 : 0)), .DW(RW), .QW(QW), .TW(DTW)) u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .in_vld (sq_vld[NSQ]),
      .num    (num),
      .den    (r_sq),
      .tag_in ({v_sq, n_sq, z_sq}),
      .out_vld(dvld[i]),
      .quo    (qv[i]),
      .tag_out(dtag[i])
    );
  end

  // ---------------- final: saturate and sign ----------------
  logic          f_vld_r;
  logic [VW-1:0] f_v_r;
  logic signed [NW-1:0] f_n_r [3];
  logic          f_z_r;
  logic [VW-1:0] tv;
  logic [2:0]    tn;
  logic          tz;
  logic [QW-1:0] qs [3];
  assign {tv, tn, tz} = dtag[0];
  assign fin_vld = dvld[0];
  always_comb begin
    for (int i = 0; i < 3; i++)
      qs[i] = (qv[i] > QW'(1 << F)) ? QW'(1 << F) : qv[i];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else if (adv) f_vld_r <= fin_vld;
    if (adv) begin
      f_v_r <= tv;
      f_z_r <= tz;
      for (int i = 0; i < 3; i++) begin
        if (tz) f_n_r[i] <= '0;
        else    f_n_r[i] <= (tn[i] ^ cw_r) ? NW'(-qs[i]) : NW'(qs[i]);
      end
    end
  end

  // ---------------- output holding stage, three vertex transfers ----------------
  logic [VW-1:0]         oh_v_r;
  logic signed [NW-1:0]  oh_n_r [3];
  logic                  oh_z_r;
  logic [INDEX_BITS-1:0] idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oh_vld_r <= 1'b0;
      slot_r   <= tfnu_pkg::SLOT_V0;
      idx_r    <= '0;
    end else begin
      if (oh_vld_r && out_ready) begin
        idx_r  <= idx_r + INDEX_BITS'(1);
        slot_r <= (slot_r == tfnu_pkg::SLOT_V2) ? tfnu_pkg::SLOT_V0 : slot_r + 2'd1;
      end
      if (adv) oh_vld_r <= f_vld_r;
    end
    if (adv) begin
      oh_v_r <= f_v_r;
      oh_n_r <= f_n_r;
      oh_z_r <= f_z_r;
    end
  end

  always_comb begin
    case (slot_r)
      tfnu_pkg::SLOT_V0: {out_pos_x, out_pos_y, out_pos_z} = oh_v_r[VW-1 -: 3*CB];
      tfnu_pkg::SLOT_V1: {out_pos_x, out_pos_y, out_pos_z} = oh_v_r[6*CB-1 -: 3*CB];
      default:           {out_pos_x, out_pos_y, out_pos_z} = oh_v_r[3*CB-1:0];
    endcase
  end
  assign out_valid            = oh_vld_r;
  assign out_vertex_index     = idx_r;
  assign out_normal_x         = oh_n_r[0];
  assign out_normal_y         = oh_n_r[1];
  assign out_normal_z         = oh_n_r[2];
  assign out_degenerate       = oh_z_r;
  assign out_last_of_triangle = (slot_r == tfnu_pkg::SLOT_V2);

`ifndef SYNTHESIS
  a_slot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !oh_vld_r |-> slot_r == tfnu_pkg::SLOT_V0) else $error("slot moved with no item");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> idx_r == $past(idx_r) + INDEX_BITS'(1)) else $error("index step");
  a_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_normal_x == '0 && out_normal_y == '0
    && out_normal_z == '0) else $error("degenerate normal not zero");
`endif
endmodule
